// File: design/dcf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and BCD decode function for the drawing command deframer.
package dcf_pkg;

    localparam int FIELD_DEPTH = 12;

    // Opcode bytes
    localparam logic [7:0] OP_FIRST     = 8'hA1;
    localparam logic [7:0] OP_LAST_KIND = 8'hA5;
    localparam logic [7:0] OP_CLEAR     = 8'hA6;

    // Command kinds; idle marks no active command
    localparam logic [2:0] KIND_CIRCLE = 3'd0;
    localparam logic [2:0] KIND_RECT   = 3'd1;
    localparam logic [2:0] KIND_LINE   = 3'd2;
    localparam logic [2:0] KIND_FILL   = 3'd3;
    localparam logic [2:0] KIND_DATE   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;
    localparam logic [2:0] KIND_IDLE   = 3'd7;

    typedef struct packed {
        logic                             emit;
        logic                             clear;
        logic [2:0]                       kind;
        logic [FIELD_DEPTH-1:0][7:0]      fields;
        logic [7:0]                       last;
    } frame_t;

    typedef struct packed {
        logic [2:0]  cmd_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [15:0] arg_c;
        logic [23:0] colour;
        logic [47:0] date_raw;
    } result_t;

    // Position of the final byte of a frame for each kind
    function automatic logic [3:0] frame_last(input logic [2:0] kind);
        logic [3:0] pos;
        case (kind)
            KIND_CIRCLE: pos = 4'd8;
            KIND_RECT:   pos = 4'd10;
            KIND_LINE:   pos = 4'd12;
            KIND_FILL:   pos = 4'd6;
            KIND_DATE:   pos = 4'd12;
            default:     pos = 4'd0;
        endcase
        return pos;
    endfunction

    // Decimal value of the nibble run from the highest nonzero nibble down to
    // the first non-decimal nibble; a non-decimal leading nibble keeps the raw word.
    function automatic logic [23:0] bcd_decode(input logic [23:0] raw);
        logic [23:0] acc;
        logic        started;
        logic        stopped;
        logic        keep_raw;
        logic [3:0]  d;
        acc      = '0;
        started  = 1'b0;
        stopped  = 1'b0;
        keep_raw = 1'b0;
        for (int i = 5; i >= 0; i--) begin
            d = raw[4*i +: 4];
            if (!started) begin
                if (d != 4'd0) begin
                    started = 1'b1;
                    if (d > 4'd9) begin
                        keep_raw = 1'b1;
                    end else begin
                        acc = {20'd0, d};
                    end
                end
            end else if (!stopped) begin
                if (d > 4'd9) begin
                    stopped = 1'b1;
                end else begin
                    acc = 24'((acc << 3) + (acc << 1) + {20'd0, d});
                end
            end
        end
        return keep_raw ? raw : acc;
    endfunction

endpackage

// File: design/dcf_collect.sv
`timescale 1ns / 1ps
// Opcode tracking and field byte collection for the drawing command deframer.
module dcf_collect (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     rx_byte,
    output dcf_pkg::frame_t frame
);
    import dcf_pkg::*;

    logic [2:0] kind_reg, kind_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] field_reg [FIELD_DEPTH];
    logic [3:0] last_pos;
    logic       store;

    always_comb begin
        last_pos    = frame_last(kind_reg);
        store       = 1'b0;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        frame.emit  = 1'b0;
        frame.clear = 1'b0;
        frame.kind  = kind_reg;
        frame.last  = rx_byte;
        for (int i = 0; i < FIELD_DEPTH; i++) begin
            frame.fields[i] = field_reg[i];
        end
        if (rx_byte inside {[OP_FIRST:OP_LAST_KIND]}) begin
            // new kind: drop anything collected so far
            kind_next = 3'(rx_byte - OP_FIRST);
            pos_next  = 4'd0;
        end else if (rx_byte == OP_CLEAR) begin
            kind_next   = KIND_IDLE;
            pos_next    = 4'd0;
            frame.emit  = 1'b1;
            frame.clear = 1'b1;
        end else if (kind_reg <= KIND_DATE) begin
            if (pos_reg < last_pos) begin
                store    = 1'b1;
                pos_next = pos_reg + 4'd1;
            end else begin
                pos_next   = 4'd0;
                frame.emit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_IDLE;
            pos_reg  <= 4'd0;
        end else if (step) begin
            kind_reg <= kind_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && store) begin
            field_reg[pos_reg] <= rx_byte;
        end
    end

    a_idle_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == KIND_IDLE) |-> (pos_reg == 4'd0))
        else $error("collection position moved while idle");

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg != KIND_IDLE) |-> (pos_reg <= frame_last(kind_reg)))
        else $error("collection position beyond frame end");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg <= KIND_DATE) || (kind_reg == KIND_IDLE))
        else $error("active kind holds a clear or unused code");

endmodule

// File: design/dcf_decode.sv
`timescale 1ns / 1ps
// BCD decode and field placement of a completed drawing command frame.
module dcf_decode (
    input  dcf_pkg::frame_t  frame,
    output dcf_pkg::result_t result
);
    import dcf_pkg::*;

    logic [FIELD_DEPTH-1:0][7:0] f;
    logic [23:0] w0, w2, w4, w6, w8;
    logic [23:0] col_raw;

    always_comb begin
        f  = frame.fields;
        w0 = bcd_decode({8'h00, f[1], f[0]});
        w2 = bcd_decode({8'h00, f[3], f[2]});
        w4 = bcd_decode({8'h00, f[5], f[4]});
        w6 = bcd_decode({8'h00, f[7], f[6]});
        w8 = bcd_decode({8'h00, f[9], f[8]});

        // colour takes the final three bytes of the frame
        case (frame.kind)
            KIND_CIRCLE: col_raw = {frame.last, f[7], f[6]};
            KIND_RECT:   col_raw = {frame.last, f[9], f[8]};
            KIND_LINE:   col_raw = {frame.last, f[11], f[10]};
            KIND_FILL:   col_raw = {frame.last, f[5], f[4]};
            KIND_DATE:   col_raw = {frame.last, f[11], f[10]};
            default:     col_raw = '0;
        endcase

        result = '0;
        if (frame.clear) begin
            result.cmd_kind = KIND_CLEAR;
        end else begin
            result.cmd_kind = frame.kind;
            result.pos_x    = w0[15:0];
            result.pos_y    = w2[15:0];
            result.colour   = bcd_decode(col_raw);
            case (frame.kind)
                KIND_CIRCLE: begin
                    result.arg_a = w4[15:0];
                end
                KIND_RECT: begin
                    result.arg_a = w4[15:0];
                    result.arg_b = w6[15:0];
                end
                KIND_LINE: begin
                    result.arg_a = w4[15:0];
                    result.arg_b = w6[15:0];
                    result.arg_c = w8[15:0];
                end
                KIND_DATE: begin
                    result.date_raw = {f[9], f[8], f[7], f[6], f[5], f[4]};
                end
                default: begin
                    result.arg_a = '0;
                end
            endcase
        end
    end

endmodule

// File: design/drawing_command_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the drawing command deframer: input register, collector, decode, result register.
// The completing byte goes through the input register; its result word is registered onto m_valid.
// Throughput: one input byte per cycle while the result side keeps m_ready high.
// The input register and the result register part the two sides; a held result stalls input.
// Reset (synchronous, aresetn low) returns to idle with no active kind and empties both registers.
module drawing_command_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_cmd_kind,
    output logic [15:0] m_pos_x,
    output logic [15:0] m_pos_y,
    output logic [15:0] m_arg_a,
    output logic [15:0] m_arg_b,
    output logic [15:0] m_arg_c,
    output logic [23:0] m_colour,
    output logic [47:0] m_date_raw
);
    import dcf_pkg::*;

    logic    in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic    m_valid_reg, m_valid_next;
    result_t result_reg;
    logic    advance;
    frame_t  frame;
    result_t result;

    // hold the input word while a finished result waits
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    dcf_collect u_collect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    dcf_decode u_decode (
        .frame  (frame),
        .result (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && frame.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && frame.emit) begin
            result_reg <= result;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_cmd_kind = result_reg.cmd_kind;
    assign m_pos_x    = result_reg.pos_x;
    assign m_pos_y    = result_reg.pos_y;
    assign m_arg_a    = result_reg.arg_a;
    assign m_arg_b    = result_reg.arg_b;
    assign m_arg_c    = result_reg.arg_c;
    assign m_colour   = result_reg.colour;
    assign m_date_raw = result_reg.date_raw;

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cmd_kind == KIND_CLEAR)) |->
        ((m_pos_x == 16'd0) && (m_pos_y == 16'd0) && (m_arg_a == 16'd0) &&
         (m_arg_b == 16'd0) && (m_arg_c == 16'd0) && (m_colour == 24'd0) &&
         (m_date_raw == 48'd0)))
        else $error("clear word carries nonzero fields");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cmd_kind <= KIND_CLEAR))
        else $error("result word with unused kind code");

    a_date_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cmd_kind != KIND_DATE)) |-> (m_date_raw == 48'd0))
        else $error("date bytes on a non-date word");

endmodule

// File: test/drawing_command_deframer_core_checker.sv
`timescale 1ns / 1ps
// Checker for the drawing command deframer: predicts command words from taken bytes and compares.
module drawing_command_deframer_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_cmd_kind,
    input  logic [15:0] m_pos_x,
    input  logic [15:0] m_pos_y,
    input  logic [15:0] m_arg_a,
    input  logic [15:0] m_arg_b,
    input  logic [15:0] m_arg_c,
    input  logic [23:0] m_colour,
    input  logic [47:0] m_date_raw,
    output int          mismatches,
    output int          backlog
);
    import dcf_pkg::*;

    logic [2:0] sel_kind;
    logic [3:0] byte_idx;
    logic [7:0] held_bytes [FIELD_DEPTH];
    result_t    pending_cmds [$];
    int         err_total = 0;
    int         word_no = 0;

    function automatic int frame_len(input logic [2:0] kind);
        case (kind)
            KIND_CIRCLE: return 9;
            KIND_RECT:   return 11;
            KIND_LINE:   return 13;
            KIND_FILL:   return 7;
            default:     return 13;
        endcase
    endfunction

    // Decimal value of the digit run from the top nonzero nibble down; a letter on top keeps raw.
    function automatic logic [23:0] bcd_value(input logic [23:0] raw, input int nibbles);
        int          k;
        logic [3:0]  d;
        logic [23:0] val;
        bit          done;
        k    = nibbles - 1;
        val  = '0;
        done = 1'b0;
        while (k >= 0 && 4'(raw >> (4 * k)) == 4'd0) k--;
        if (k < 0) return '0;
        if (4'(raw >> (4 * k)) > 4'd9) return raw;
        while (k >= 0 && !done) begin
            d = 4'(raw >> (4 * k));
            if (d > 4'd9) begin
                done = 1'b1;
            end else begin
                val = 24'(val * 10 + d);
                k--;
            end
        end
        return val;
    endfunction

    function automatic logic [15:0] coord(input logic [7:0] lo, input logic [7:0] hi);
        return 16'(bcd_value({8'd0, hi, lo}, 4));
    endfunction

    // Advance the collector by one byte; returns 1 when a command word comes out.
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [7:0] fr [13];
        int         len;
        r = '0;
        if (b >= OP_FIRST && b <= OP_LAST_KIND) begin
            sel_kind = 3'(b - OP_FIRST);
            byte_idx = '0;
            return 1'b0;
        end
        if (b == OP_CLEAR) begin
            sel_kind   = KIND_IDLE;
            byte_idx   = '0;
            r.cmd_kind = KIND_CLEAR;
            return 1'b1;
        end
        if (sel_kind > KIND_DATE) return 1'b0;
        len = frame_len(sel_kind);
        if (int'(byte_idx) < len - 1) begin
            held_bytes[byte_idx] = b;
            byte_idx = byte_idx + 4'd1;
            return 1'b0;
        end
        for (int i = 0; i < 13; i++) fr[i] = (i < FIELD_DEPTH) ? held_bytes[i] : 8'd0;
        fr[len - 1] = b;
        byte_idx    = '0;
        r.cmd_kind  = sel_kind;
        r.pos_x     = coord(fr[0], fr[1]);
        r.pos_y     = coord(fr[2], fr[3]);
        r.colour    = bcd_value({fr[len - 1], fr[len - 2], fr[len - 3]}, 6);
        case (sel_kind)
            KIND_CIRCLE: begin
                r.arg_a = coord(fr[4], fr[5]);
            end
            KIND_RECT: begin
                r.arg_a = coord(fr[4], fr[5]);
                r.arg_b = coord(fr[6], fr[7]);
            end
            KIND_LINE: begin
                r.arg_a = coord(fr[4], fr[5]);
                r.arg_b = coord(fr[6], fr[7]);
                r.arg_c = coord(fr[8], fr[9]);
            end
            KIND_DATE: begin
                r.date_raw = {fr[9], fr[8], fr[7], fr[6], fr[5], fr[4]};
            end
            default: begin
            end
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got_v,
                                   input logic [47:0] want_v);
        $display("ERROR word %0d: %s got %0h want %0h", word_no, what, got_v, want_v);
        err_total++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            sel_kind = KIND_IDLE;
            byte_idx = '0;
            for (int i = 0; i < FIELD_DEPTH; i++) held_bytes[i] = 8'd0;
            pending_cmds.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (deframe_byte(s_rx_byte, want)) pending_cmds.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_cmds.size() == 0) begin
                    report_mismatch("unexpected word, kind", 48'(m_cmd_kind), '0);
                end else begin
                    want = pending_cmds.pop_front();
                    if (m_cmd_kind !== want.cmd_kind)
                        report_mismatch("cmd_kind", 48'(m_cmd_kind), 48'(want.cmd_kind));
                    if (m_pos_x !== want.pos_x)
                        report_mismatch("pos_x", 48'(m_pos_x), 48'(want.pos_x));
                    if (m_pos_y !== want.pos_y)
                        report_mismatch("pos_y", 48'(m_pos_y), 48'(want.pos_y));
                    if (m_arg_a !== want.arg_a)
                        report_mismatch("arg_a", 48'(m_arg_a), 48'(want.arg_a));
                    if (m_arg_b !== want.arg_b)
                        report_mismatch("arg_b", 48'(m_arg_b), 48'(want.arg_b));
                    if (m_arg_c !== want.arg_c)
                        report_mismatch("arg_c", 48'(m_arg_c), 48'(want.arg_c));
                    if (m_colour !== want.colour)
                        report_mismatch("colour", 48'(m_colour), 48'(want.colour));
                    if (m_date_raw !== want.date_raw)
                        report_mismatch("date_raw", m_date_raw, want.date_raw);
                end
                word_no++;
            end
        end
        backlog    <= pending_cmds.size();
        mismatches <= err_total;
    end

endmodule

// File: test/drawing_command_deframer_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the drawing command deframer: clock, reset, byte stream, result stalls, verdict.
module drawing_command_deframer_core_test;
    import dcf_pkg::*;

    localparam int BYTE_TARGET  = 1750;
    localparam int CALM_FROM    = 1550;
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_cmd_kind;
    logic [15:0] m_pos_x;
    logic [15:0] m_pos_y;
    logic [15:0] m_arg_a;
    logic [15:0] m_arg_b;
    logic [15:0] m_arg_c;
    logic [23:0] m_colour;
    logic [47:0] m_date_raw;

    int mismatches;
    int backlog;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    drawing_command_deframer_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cmd_kind (m_cmd_kind),
        .m_pos_x    (m_pos_x),
        .m_pos_y    (m_pos_y),
        .m_arg_a    (m_arg_a),
        .m_arg_b    (m_arg_b),
        .m_arg_c    (m_arg_c),
        .m_colour   (m_colour),
        .m_date_raw (m_date_raw)
    );

    drawing_command_deframer_core_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cmd_kind (m_cmd_kind),
        .m_pos_x    (m_pos_x),
        .m_pos_y    (m_pos_y),
        .m_arg_a    (m_arg_a),
        .m_arg_b    (m_arg_b),
        .m_arg_c    (m_arg_c),
        .m_colour   (m_colour),
        .m_date_raw (m_date_raw),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // End the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("drawing_command_deframer_core: mismatch");
            $finish;
        end
    end

    // Result side: short random stalls, plus one long hold-off on request.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input bit tally);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (tally) bytes_sent++;
    endtask

    // Field byte that is never an opcode: BCD digits, zero, letter nibbles or anything else.
    function automatic logic [7:0] pick_field();
        logic [7:0] b;
        b = OP_FIRST;
        while (b >= OP_FIRST && b <= OP_CLEAR) begin
            case ($urandom_range(0, 4))
                0, 1:    b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                2:       b = 8'h00;
                3:       b = {4'($urandom_range(10, 15)), 4'($urandom_range(0, 15))};
                default: b = 8'($urandom_range(0, 255));
            endcase
        end
        return b;
    endfunction

    task automatic send_list(input logic [7:0] list [$]);
        foreach (list[i]) send_byte(list[i], 1'b1);
    endtask

    initial begin
        logic [2:0] kind;
        int         len;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Ignored byte in idle, clear, then a fill with zero, top decimal and raw colour.
        send_list('{8'h00, OP_CLEAR, 8'hA4, 8'h00, 8'h00, 8'h99, 8'h99, 8'hFF, 8'hFF, 8'hFF});
        // Opcodes back to back and mid-command, then a line with truncated and raw words.
        send_list('{8'hA2, 8'h55, 8'hA5, 8'hA1, 8'h12, 8'hA3,
                    8'h34, 8'h12, 8'hF4, 8'h12, 8'h07, 8'hB0, 8'h00, 8'h00,
                    8'h50, 8'h00, 8'h01, 8'h23, 8'h9E});

        while (bytes_sent < BYTE_TARGET) begin
            idle_on = (bytes_sent < CALM_FROM) && ((bytes_sent / 250) % 3 != 2);
            if (bytes_sent > 600 && !hold_req) hold_req = 1'b1;
            kind = 3'($urandom_range(0, 4));
            len  = int'(frame_last(kind)) + 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    send_byte(OP_FIRST + 8'(kind), 1'b1);
                    repeat ($urandom_range(1, 3)) begin
                        for (int i = 0; i < len; i++) send_byte(pick_field(), 1'b1);
                    end
                end
                7: begin
                    // Break off a frame; the next opcode restarts collection.
                    send_byte(OP_FIRST + 8'(kind), 1'b1);
                    repeat ($urandom_range(1, len - 1)) send_byte(pick_field(), 1'b1);
                end
                8: begin
                    send_byte(OP_CLEAR, 1'b1);
                    repeat ($urandom_range(0, 3)) send_byte(pick_field(), 1'b0);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            endcase
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (mismatches == 0 && backlog == 0) begin
            $display("drawing_command_deframer_core: match");
        end else begin
            $display("drawing_command_deframer_core: mismatch");
        end
        $finish;
    end

endmodule
